[design/oqir_pkg.sv]
// oqir_pkg: shared widths, codes and item types for the ordered queue block.
// No dependencies; compiled first.
package oqir_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int CAP_W         = 5;
	localparam int CMD_W         = 2;
	localparam int POS_W         = 4;
	localparam int NAME_W        = 32;
	localparam int ID_W          = 37;
	localparam int OCC_OUT_W     = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ    = 2'd0,
		CMD_DEQ    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_code_t;

	typedef enum logic {
		FSM_EMPTY = 1'b0,
		FSM_HOLD  = 1'b1
	} ctl_state_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [POS_W-1:0]  position;
		logic [NAME_W-1:0] name_handle;
		logic [ID_W-1:0]   id_number;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [NAME_W-1:0]    removed_name;
		logic [ID_W-1:0]      removed_id;
		logic [OCC_OUT_W-1:0] occupancy_after;
		logic                 now_empty;
		logic                 now_full;
	} result_item_t;

	// controller -> datapath
	typedef struct packed {
		logic         exec;
		logic         do_enq;
		logic         do_rem;
		logic         at_pos;
		status_code_t status;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic full;
		logic pos_ok;
	} dp_stat_t;

endpackage

[design/oqir_chan_if.sv]
// oqir_chan_if: valid/ready channel carrying one payload of type T.
// No dependencies; payload type is set where the channel is instantiated.
interface oqir_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[design/oqir_ctrl.sv]
// oqir_ctrl: controller FSM - handshakes, command decode and status choice.
// Depends on oqir_pkg.
module oqir_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [oqir_pkg::CMD_W-1:0]   req_command,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	input  oqir_pkg::dp_stat_t           stat,
	output oqir_pkg::dp_cmd_t            cmd
);
	import oqir_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_nxt;
	logic       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_EMPTY;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		// result slot is free, or is being emptied this cycle
		req_ready = (state_q == FSM_EMPTY) || rsp_ready;
		rsp_valid = (state_q == FSM_HOLD);
		accept    = req_valid && req_ready;

		cmd        = '0;
		cmd.status = ST_DONE;
		if (accept) begin
			cmd.exec = 1'b1;
			case (cmd_code_t'(req_command))
				CMD_ENQ: begin
					if (stat.full) cmd.status = ST_FULL;
					else           cmd.do_enq = 1'b1;
				end
				CMD_DEQ: begin
					if (stat.empty) cmd.status = ST_EMPTY;
					else            cmd.do_rem = 1'b1;
				end
				CMD_REMOVE: begin
					// empty check takes priority over range check
					if (stat.empty)        cmd.status = ST_EMPTY;
					else if (!stat.pos_ok) cmd.status = ST_RANGE;
					else begin
						cmd.do_rem = 1'b1;
						cmd.at_pos = 1'b1;
					end
				end
				default: ; // no-op code
			endcase
		end

		state_nxt = state_q;
		case (state_q)
			FSM_EMPTY: begin
				if (accept) state_nxt = FSM_HOLD;
			end
			FSM_HOLD: begin
				if (rsp_ready && !accept) state_nxt = FSM_EMPTY;
			end
			default: state_nxt = FSM_EMPTY;
		endcase
	end

endmodule

[design/oqir_dpath.sv]
// oqir_dpath: entry registers with parallel shift-up, occupancy, capacity
// register and result register. Depends on oqir_pkg.
module oqir_dpath #(
	parameter int DEPTH = oqir_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  oqir_pkg::dp_cmd_t             cmd,
	output oqir_pkg::dp_stat_t            stat,
	input  oqir_pkg::cmd_item_t           item,
	input  logic                          cfg_we,
	input  logic [oqir_pkg::CAP_W-1:0]    cfg_data,
	output oqir_pkg::result_item_t        result
);
	import oqir_pkg::*;

	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	logic [CAP_W-1:0]  cap_q;
	logic [OCC_W-1:0]  occ_q;
	logic [OCC_W-1:0]  occ_nxt;
	logic [NAME_W-1:0] names_q [DEPTH];
	logic [ID_W-1:0]   ids_q [DEPTH];
	result_item_t      res_q;

	logic [CMP_W-1:0]  cap_eff;
	logic [CMP_W-1:0]  occ_cmp;
	logic [CMP_W-1:0]  rem_idx;
	logic [IDX_W-1:0]  rd_idx;
	logic [NAME_W-1:0] rd_name;
	logic [ID_W-1:0]   rd_id;

	always_comb begin
		occ_cmp     = CMP_W'(occ_q);
		// capacity saturates at the number of entries built
		cap_eff     = (CMP_W'(cap_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_q);
		stat.empty  = (occ_q == '0);
		stat.full   = (occ_cmp >= cap_eff);
		stat.pos_ok = (CMP_W'(item.position) < occ_cmp);

		rem_idx = cmd.at_pos ? CMP_W'(item.position) : '0;
		rd_idx  = IDX_W'(rem_idx);
		rd_name = names_q[rd_idx];
		rd_id   = ids_q[rd_idx];

		if (cmd.do_enq)      occ_nxt = occ_q + OCC_W'(1);
		else if (cmd.do_rem) occ_nxt = occ_q - OCC_W'(1);
		else                 occ_nxt = occ_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			occ_q <= '0;
		end else begin
			if (cfg_we) cap_q <= cfg_data;
			occ_q <= occ_nxt;
		end
	end

	// entries: tail load on enqueue, every entry at or above the gap
	// takes its upper neighbour on removal
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (cmd.do_enq && occ_cmp == CMP_W'(i)) begin
				names_q[i] <= item.name_handle;
				ids_q[i]   <= item.id_number;
			end
		end
		for (int i = 0; i < DEPTH - 1; i++) begin
			if (cmd.do_rem && CMP_W'(i) >= rem_idx) begin
				names_q[i] <= names_q[i+1];
				ids_q[i]   <= ids_q[i+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_q.status          <= cmd.status;
			res_q.removed_name    <= cmd.do_rem ? rd_name : '0;
			res_q.removed_id      <= cmd.do_rem ? rd_id : '0;
			res_q.occupancy_after <= OCC_OUT_W'(occ_nxt);
			res_q.now_empty       <= (occ_nxt == '0);
			res_q.now_full        <= (CMP_W'(occ_nxt) >= cap_eff);
		end
	end

	assign result = res_q;

`ifndef NO_ASSERTIONS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_cmp <= CMP_W'(DEPTH))
		else $error("occupancy above depth");

	a_occ_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |=> $stable(occ_q))
		else $error("occupancy moved without a command");

	a_enq_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_enq |-> !stat.full && cmd.exec && !cmd.do_rem)
		else $error("enqueue issued while full");

	a_rem_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_rem |=> occ_q == $past(occ_q) - OCC_W'(1))
		else $error("removal did not shrink the queue");

	a_rem_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_rem && cmd.at_pos |-> stat.pos_ok && !stat.empty)
		else $error("removal at a position not held");
`endif

endmodule

[design/ordered_queue_indexed_removal.sv]
// Ordered queue with indexed removal: enqueue at tail, remove head, remove at
// any position with compaction. The result is valid in the cycle after the
// request transfer. One command per cycle unless a held result is stalled;
// entries at or above the gap load from their upper neighbour in parallel.
// Reset (arst_n low, asynchronous): queue empty, capacity 16, no result held.
// Entry contents are not cleared; only entries below the occupancy are read.
module ordered_queue_indexed_removal #(
	parameter int DEPTH = oqir_pkg::DEPTH_DEFAULT
) (
	input logic         clk,
	input logic         arst_n,
	oqir_chan_if.sink   request,
	oqir_chan_if.source response,
	oqir_chan_if.sink   cfg
);
	import oqir_pkg::*;

	dp_cmd_t      dp_cmd;
	dp_stat_t     dp_stat;
	result_item_t result;
	logic         req_ready;
	logic         rsp_valid;

	// Capacity writes are always taken; the user must write only while idle,
	// so a write never races a command in flight. The block does not enforce it.
	assign cfg.ready = 1'b1;

	// Controller: owns the result slot state, decides each command's
	// outcome from the datapath flags and issues the datapath strobes.
	oqir_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (request.valid),
		.req_ready   (req_ready),
		.req_command (request.payload.command),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (response.ready),
		.stat        (dp_stat),
		.cmd         (dp_cmd)
	);

	// Datapath: entry row, occupancy counter, capacity register and the
	// output register that holds the result while the response is stalled.
	oqir_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (dp_cmd),
		.stat     (dp_stat),
		.item     (request.payload),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.payload),
		.result   (result)
	);

	assign request.ready    = req_ready;
	assign response.valid   = rsp_valid;
	assign response.payload = result;

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// tb: self-checking bench for ordered_queue_indexed_removal (enqueue, dequeue, remove at position).
// Depends on oqir_pkg, oqir_chan_if and the block itself; needs no other files.
module tb;
	import oqir_pkg::*;

	localparam int DEPTH       = DEPTH_DEFAULT;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 200;
	localparam logic [ID_W-1:0] ID_MAX = 37'd99999999999;

	// one row of the directed table: either a capacity write or a command,
	// the latter optionally carrying a hand-typed expected result
	typedef struct {
		bit            is_cap;
		logic [4:0]    cap;
		cmd_item_t     item;
		bit            typed;
		result_item_t  res;
	} dir_row_t;

	logic clk;
	logic arst_n;

	oqir_chan_if #(.T(cmd_item_t))         request ();
	oqir_chan_if #(.T(result_item_t))      response ();
	oqir_chan_if #(.T(logic [CAP_W-1:0]))  cfg ();

	ordered_queue_indexed_removal #(.DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.response (response),
		.cfg      (cfg)
	);

	// shadow of the queue contents and the capacity register
	logic [NAME_W-1:0] shadow_names [DEPTH];
	logic [ID_W-1:0]   shadow_ids [DEPTH];
	int                held;
	logic [CAP_W-1:0]  cap_reg;

	result_item_t pending_results [$];
	dir_row_t     dir_rows [$];

	int  send_idle_pct;
	int  stall_pct;
	int  hold_token;
	int  hold_seen;
	int  hold_left;
	int  cycle_count;
	bit  failed;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: the run is far shorter than this when the block behaves
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t timeout, %0d results still outstanding", $time, pending_results.size());
		$display("tb: failure");
		$finish;
	end

	// Next state of the queue and the result for one command.
	// Rejected or flagged commands leave the shadow untouched.
	function automatic result_item_t queue_predict(input cmd_item_t c);
		result_item_t r;
		int cap_eff;
		int rm_at;
		r       = '0;
		rm_at   = -1;
		cap_eff = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
		case (cmd_code_t'(c.command))
			CMD_ENQ: begin
				if (held >= cap_eff) begin
					r.status = ST_FULL;
				end else begin
					shadow_names[held] = c.name_handle;
					shadow_ids[held]   = c.id_number;
					held++;
				end
			end
			CMD_DEQ: begin
				if (held == 0) r.status = ST_EMPTY;
				else rm_at = 0;
			end
			CMD_REMOVE: begin
				// empty is reported ahead of a bad position
				if (held == 0) r.status = ST_EMPTY;
				else if (int'(c.position) >= held) r.status = ST_RANGE;
				else rm_at = int'(c.position);
			end
			default: ;	// unused code: no operation
		endcase
		if (rm_at >= 0) begin
			r.removed_name = shadow_names[rm_at];
			r.removed_id   = shadow_ids[rm_at];
			// later entries close the gap, order kept
			for (int i = rm_at; i + 1 < held; i++) begin
				shadow_names[i] = shadow_names[i + 1];
				shadow_ids[i]   = shadow_ids[i + 1];
			end
			held--;
		end
		r.occupancy_after = held[OCC_OUT_W-1:0];
		r.now_empty       = (held == 0);
		r.now_full        = (held >= cap_eff);
		return r;
	endfunction

	function automatic dir_row_t cmd_row(input cmd_code_t cmd, input logic [POS_W-1:0] pos,
			input logic [NAME_W-1:0] name, input logic [ID_W-1:0] id);
		dir_row_t row;
		row = '{is_cap: 1'b0, cap: '0, item: '{cmd, pos, name, id}, typed: 1'b0, res: '0};
		return row;
	endfunction

	// command row with a hand-typed result; nothing is removed on these
	function automatic dir_row_t chk_row(input cmd_code_t cmd, input logic [POS_W-1:0] pos,
			input logic [NAME_W-1:0] name, input logic [ID_W-1:0] id,
			input status_code_t st, input int occ, input bit is_empty, input bit is_full);
		dir_row_t row;
		row       = cmd_row(cmd, pos, name, id);
		row.typed = 1'b1;
		row.res   = '{st, '0, '0, occ[OCC_OUT_W-1:0], is_empty, is_full};
		return row;
	endfunction

	function automatic dir_row_t cap_row(input logic [CAP_W-1:0] value);
		dir_row_t row;
		row        = '{is_cap: 1'b1, cap: value, item: '0, typed: 1'b0, res: '0};
		return row;
	endfunction

	// Offer one command, with random idle cycles first, and hold it until the
	// transfer. valid is left high so back-to-back commands need no toggle.
	task automatic send_cmd(input cmd_item_t item, input bit typed, input result_item_t res);
		result_item_t predicted;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			request.valid <= 1'b0;
			@(posedge clk);
		end
		request.valid   <= 1'b1;
		request.payload <= item;
		do @(posedge clk); while (!request.ready);
		// transfer at this edge: state moves on in the shadow now
		predicted = queue_predict(item);
		pending_results.push_back(typed ? res : predicted);
	endtask

	// Capacity is only changed with the block drained.
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		request.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg.valid   <= 1'b1;
		cfg.payload <= value;
		do @(posedge clk); while (!cfg.ready);
		cap_reg    = value;
		cfg.valid <= 1'b0;
	endtask

	// Random commands. Removals mostly aim at a held entry so compaction is
	// exercised; the rest hit the empty and out-of-range paths.
	task automatic run_phase(input int count, input int enq_pct);
		cmd_item_t item;
		int roll;
		longint unsigned id_raw;
		for (int n = 0; n < count; n++) begin
			roll   = $urandom_range(99);
			id_raw = {$urandom, $urandom};
			item.name_handle = $urandom;
			item.id_number   = ID_W'(id_raw % 64'd100000000000);
			item.position    = POS_W'($urandom_range(15));
			case ($urandom_range(15))
				0: item.name_handle = '0;
				1: item.name_handle = '1;
				2: item.id_number = '0;
				3: item.id_number = ID_MAX;
				default: ;
			endcase
			if (roll < enq_pct) begin
				item.command = CMD_ENQ;
			end else if (roll < 95) begin
				item.command = ($urandom_range(2) == 0) ? CMD_DEQ : CMD_REMOVE;
				if (held > 0 && $urandom_range(9) < 8)
					item.position = POS_W'($urandom_range(held - 1));
			end else begin
				item.command = CMD_NOP;
			end
			send_cmd(item, 1'b0, '0);
		end
	endtask

	// receiver: random stalls, plus a long hold-off whenever the token moves
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			response.ready <= 1'b0;
		end else begin
			response.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// result checker: oldest expectation against each result transfer
	always @(posedge clk) begin
		result_item_t want;
		result_item_t got;
		if (arst_n && response.valid && response.ready) begin
			got = response.payload;
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result %p", $time, got);
				failed = 1'b1;
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status) begin
					$display("%0t status: expected %0d, got %0d", $time, want.status, got.status);
					failed = 1'b1;
				end
				if (got.removed_name !== want.removed_name) begin
					$display("%0t removed_name: expected %h, got %h", $time,
						want.removed_name, got.removed_name);
					failed = 1'b1;
				end
				if (got.removed_id !== want.removed_id) begin
					$display("%0t removed_id: expected %0d, got %0d", $time,
						want.removed_id, got.removed_id);
					failed = 1'b1;
				end
				if (got.occupancy_after !== want.occupancy_after) begin
					$display("%0t occupancy_after: expected %0d, got %0d", $time,
						want.occupancy_after, got.occupancy_after);
					failed = 1'b1;
				end
				if (got.now_empty !== want.now_empty) begin
					$display("%0t now_empty: expected %b, got %b", $time,
						want.now_empty, got.now_empty);
					failed = 1'b1;
				end
				if (got.now_full !== want.now_full) begin
					$display("%0t now_full: expected %b, got %b", $time,
						want.now_full, got.now_full);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		arst_n           = 1'b0;
		request.valid    = 1'b0;
		request.payload  = '0;
		response.ready   = 1'b0;
		cfg.valid        = 1'b0;
		cfg.payload      = '0;
		send_idle_pct    = 0;
		stall_pct        = 0;
		hold_token       = 0;
		hold_seen        = 0;
		hold_left        = 0;
		failed           = 1'b0;
		held             = 0;
		cap_reg          = CAP_RESET;

		// Directed: empty queue errors, field extremes, out-of-range
		// positions, mid-queue removal, capacity of one and of zero, a
		// capacity beyond the depth, and capacity dropped below the count.
		dir_rows = '{
			chk_row(CMD_DEQ,    4'd0,  32'h0,         37'd0,  ST_EMPTY, 0, 1'b1, 1'b0),
			chk_row(CMD_REMOVE, 4'd0,  32'h0,         37'd0,  ST_EMPTY, 0, 1'b1, 1'b0),
			chk_row(CMD_REMOVE, 4'd15, 32'h0,         37'd0,  ST_EMPTY, 0, 1'b1, 1'b0),
			chk_row(CMD_NOP,    4'd9,  32'hFFFF_FFFF, ID_MAX, ST_DONE,  0, 1'b1, 1'b0),
			chk_row(CMD_ENQ,    4'd0,  32'h0,         37'd0,  ST_DONE,  1, 1'b0, 1'b0),
			chk_row(CMD_ENQ,    4'd15, 32'hFFFF_FFFF, ID_MAX, ST_DONE,  2, 1'b0, 1'b0),
			cmd_row(CMD_ENQ,    4'd0,  32'h1234_5678, 37'd555),
			chk_row(CMD_REMOVE, 4'd3,  32'h0,         37'd0,  ST_RANGE, 3, 1'b0, 1'b0),
			chk_row(CMD_REMOVE, 4'd15, 32'h0,         37'd0,  ST_RANGE, 3, 1'b0, 1'b0),
			cmd_row(CMD_NOP,    4'd5,  32'hDEAD_BEEF, 37'd77),
			cmd_row(CMD_REMOVE, 4'd1,  32'h0,         37'd0),
			cmd_row(CMD_DEQ,    4'd7,  32'h0,         37'd0),
			cap_row(5'd1),
			chk_row(CMD_ENQ,    4'd0,  32'hA5A5_A5A5, 37'd7,  ST_FULL,  1, 1'b0, 1'b1),
			cap_row(5'd0),
			chk_row(CMD_ENQ,    4'd0,  32'hA5A5_A5A5, 37'd7,  ST_FULL,  1, 1'b0, 1'b1),
			cmd_row(CMD_DEQ,    4'd0,  32'h0,         37'd0),
			chk_row(CMD_ENQ,    4'd0,  32'h5A5A_5A5A, 37'd9,  ST_FULL,  0, 1'b1, 1'b1),
			cap_row(5'd31),
			cmd_row(CMD_ENQ,    4'd0,  32'h0000_0001, 37'd1),
			cmd_row(CMD_ENQ,    4'd0,  32'h0000_0002, 37'd2),
			cap_row(5'd1),
			chk_row(CMD_ENQ,    4'd0,  32'h0000_0003, 37'd3,  ST_FULL,  2, 1'b0, 1'b1),
			cmd_row(CMD_REMOVE, 4'd1,  32'h0,         37'd0)
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cap) write_capacity(dir_rows[i].cap);
			else send_cmd(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
		end

		// random phases, each with its own capacity and idling mix
		write_capacity(5'd16);
		run_phase(100, 55);

		write_capacity(5'd5);
		send_idle_pct = 73;
		run_phase(90, 50);

		write_capacity(5'd31);
		send_idle_pct = 0;
		stall_pct     = 73;
		run_phase(90, 60);

		write_capacity(5'd1);
		send_idle_pct = 37;
		stall_pct     = 37;
		run_phase(60, 50);

		write_capacity(5'd0);
		send_idle_pct = 0;
		stall_pct     = 0;
		run_phase(20, 50);

		write_capacity(CAP_W'($urandom_range(2, 15)));
		send_idle_pct = 37;
		stall_pct     = 37;
		run_phase(90, 55);

		// back-pressure: receiver holds off while commands keep coming,
		// so the result stage fills and the request side must stall
		write_capacity(5'd16);
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_token   <= hold_token + 1;
		run_phase(50, 70);

		request.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (!failed) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
